### rtl/resample_three_quarter_iir_core_macros.svh
// Assertion macros used by the resampler top level.
`ifndef RESAMPLE_THREE_QUARTER_IIR_CORE_MACROS_SVH
`define RESAMPLE_THREE_QUARTER_IIR_CORE_MACROS_SVH

// Clocked check, masked while reset is held.
`define RTQI_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked check that also runs through reset.
`define RTQI_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/rtqi_pkg.sv
// Shared types, constants, microcode program and arithmetic helpers of the resampler.
`timescale 1ns / 1ps
package rtqi_pkg;

  // Default geometry
  localparam int NUM_SECTIONS_DEF = 3;
  localparam int UP_FACTOR_DEF    = 3;
  localparam int DOWN_FACTOR_DEF  = 4;

  // Fixed-point widths
  localparam int SAMPLE_W = 16;
  localparam int HIST_W   = 32;            // history, 8 fraction bits
  localparam int COEF_W   = 16;            // Q1.15 magnitude
  localparam int FRAC_Q15 = 15;
  localparam int VSUM_W   = HIST_W + 3;    // wn + 2*w0 + w1
  localparam int PROD_W   = VSUM_W + COEF_W + 1;
  localparam int SHR_W    = PROD_W - FRAC_Q15;

  // Coefficient sets
  localparam int COEF_SETS = 3;
  localparam int CSEL_W    = 2;
  typedef logic [CSEL_W-1:0] csel_t;
  localparam csel_t CSEL_LAST = csel_t'(COEF_SETS - 1);

  // Microcode
  localparam int STEP_W = 4;
  typedef logic [STEP_W-1:0] step_t;

  localparam step_t ST_WAIT  = step_t'(0);
  localparam step_t ST_LOADX = step_t'(1);
  localparam step_t ST_SUB1  = step_t'(2);
  localparam step_t ST_SUB2  = step_t'(3);
  localparam step_t ST_WN    = step_t'(4);
  localparam step_t ST_VSUM  = step_t'(5);
  localparam step_t ST_MULG  = step_t'(6);
  localparam step_t ST_YOUT  = step_t'(7);
  localparam step_t ST_HOLD  = step_t'(8);
  localparam step_t ST_EMIT  = step_t'(9);
  localparam step_t ST_DONE  = step_t'(10);

  typedef enum logic [3:0] {
    OP_NOP,
    OP_WAIT,
    OP_LOADX,
    OP_SUB1,
    OP_SUB2,
    OP_WN,
    OP_VSUM,
    OP_MULG,
    OP_YOUT,
    OP_EMIT
  } dp_op_t;

  typedef enum logic [2:0] {
    C_NEXT,
    C_ALWAYS,
    C_NO_ITEM,
    C_SEC_MORE,
    C_UP_MORE,
    C_OUT_BUSY
  } cond_t;

  typedef struct packed {
    dp_op_t op;
    cond_t  cond;
    step_t  target;
  } ucode_t;

  // Sequencer to datapath and output stage
  typedef struct packed {
    dp_op_t op;
    csel_t  csel;
  } ctrl_t;

  // Top level to sequencer
  typedef struct packed {
    logic item_accept;
    logic out_stall;
  } seq_stat_t;

  function automatic ucode_t ucode_rom(input step_t step);
    ucode_t w;
    unique case (step)
      ST_WAIT:  w = '{op: OP_WAIT,  cond: C_NO_ITEM,  target: ST_WAIT};
      ST_LOADX: w = '{op: OP_LOADX, cond: C_NEXT,     target: ST_WAIT};
      ST_SUB1:  w = '{op: OP_SUB1,  cond: C_NEXT,     target: ST_WAIT};
      ST_SUB2:  w = '{op: OP_SUB2,  cond: C_NEXT,     target: ST_WAIT};
      ST_WN:    w = '{op: OP_WN,    cond: C_NEXT,     target: ST_WAIT};
      ST_VSUM:  w = '{op: OP_VSUM,  cond: C_NEXT,     target: ST_WAIT};
      ST_MULG:  w = '{op: OP_MULG,  cond: C_NEXT,     target: ST_WAIT};
      ST_YOUT:  w = '{op: OP_YOUT,  cond: C_SEC_MORE, target: ST_LOADX};
      ST_HOLD:  w = '{op: OP_NOP,   cond: C_OUT_BUSY, target: ST_HOLD};
      ST_EMIT:  w = '{op: OP_EMIT,  cond: C_UP_MORE,  target: ST_LOADX};
      ST_DONE:  w = '{op: OP_NOP,   cond: C_ALWAYS,   target: ST_WAIT};
      default:  w = '{op: OP_NOP,   cond: C_ALWAYS,   target: ST_WAIT};
    endcase
    return w;
  endfunction

  function automatic logic [COEF_W-1:0] coef_fb1(input csel_t c);
    logic [COEF_W-1:0] r;
    unique case (c)
      csel_t'(0): r = COEF_W'(24302);
      csel_t'(1): r = COEF_W'(18352);
      default:    r = COEF_W'(16079);
    endcase
    return r;
  endfunction

  function automatic logic [COEF_W-1:0] coef_fb2(input csel_t c);
    logic [COEF_W-1:0] r;
    unique case (c)
      csel_t'(0): r = COEF_W'(20500);
      csel_t'(1): r = COEF_W'(7457);
      default:    r = COEF_W'(2475);
    endcase
    return r;
  endfunction

  function automatic logic [COEF_W-1:0] coef_gain(input csel_t c);
    logic [COEF_W-1:0] r;
    unique case (c)
      csel_t'(0): r = COEF_W'(19392);
      csel_t'(1): r = COEF_W'(14644);
      default:    r = COEF_W'(12830);
    endcase
    return r;
  endfunction

  // Clamp a shifted product to 32 bits
  function automatic logic signed [HIST_W-1:0] sat32(input logic signed [SHR_W-1:0] v);
    logic signed [HIST_W-1:0] r;
    if (v[SHR_W-1:HIST_W-1] == '0 || v[SHR_W-1:HIST_W-1] == '1) begin
      r = v[HIST_W-1:0];
    end else if (v[SHR_W-1]) begin
      r = {1'b1, {(HIST_W-1){1'b0}}};
    end else begin
      r = {1'b0, {(HIST_W-1){1'b1}}};
    end
    return r;
  endfunction

endpackage

### rtl/rtqi_seq.sv
// Microcode sequencer: step counter, program table, section and zero-stuff counters.
`timescale 1ns / 1ps
module rtqi_seq #(
  parameter int NUM_SECTIONS = rtqi_pkg::NUM_SECTIONS_DEF,
  parameter int UP_FACTOR    = rtqi_pkg::UP_FACTOR_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  rtqi_pkg::seq_stat_t stat,
  output rtqi_pkg::ctrl_t    ctrl
);

  localparam int SEC_W = (NUM_SECTIONS > 1) ? $clog2(NUM_SECTIONS) : 1;
  localparam int UP_W  = (UP_FACTOR > 1) ? $clog2(UP_FACTOR) : 1;

  rtqi_pkg::step_t  step;
  rtqi_pkg::step_t  step_next;
  rtqi_pkg::ucode_t uw;
  logic [SEC_W-1:0] sec;
  logic [UP_W-1:0]  up;
  logic             sec_last;
  logic             up_last;
  logic             take_jump;

  assign uw       = rtqi_pkg::ucode_rom(step);
  assign sec_last = (sec == SEC_W'(NUM_SECTIONS - 1));
  assign up_last  = (up == UP_W'(UP_FACTOR - 1));

  always_comb begin
    unique case (uw.cond)
      rtqi_pkg::C_NEXT:     take_jump = 1'b0;
      rtqi_pkg::C_ALWAYS:   take_jump = 1'b1;
      rtqi_pkg::C_NO_ITEM:  take_jump = !stat.item_accept;
      rtqi_pkg::C_SEC_MORE: take_jump = !sec_last;
      rtqi_pkg::C_UP_MORE:  take_jump = !up_last;
      rtqi_pkg::C_OUT_BUSY: take_jump = stat.out_stall;
      default:              take_jump = 1'b1;
    endcase
    step_next = take_jump ? uw.target : step + rtqi_pkg::step_t'(1);
  end

  // Clamp the coefficient set: later sections reuse the last set
  always_comb begin
    ctrl.op = uw.op;
    if (32'(sec) < rtqi_pkg::COEF_SETS - 1) begin
      ctrl.csel = rtqi_pkg::csel_t'(sec);
    end else begin
      ctrl.csel = rtqi_pkg::CSEL_LAST;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= rtqi_pkg::ST_WAIT;
      sec  <= '0;
      up   <= '0;
    end else begin
      step <= step_next;
      if (uw.op == rtqi_pkg::OP_WAIT && stat.item_accept) begin
        sec <= '0;
        up  <= '0;
      end
      if (uw.op == rtqi_pkg::OP_YOUT) begin
        sec <= sec_last ? '0 : sec + SEC_W'(1);
      end
      if (uw.op == rtqi_pkg::OP_EMIT && !up_last) begin
        up <= up + UP_W'(1);
      end
    end
  end

endmodule

### rtl/rtqi_dp.sv
// Biquad datapath: shared multiplier, accumulator and rotating section history.
`timescale 1ns / 1ps
module rtqi_dp #(
  parameter int NUM_SECTIONS = rtqi_pkg::NUM_SECTIONS_DEF
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  rtqi_pkg::ctrl_t                         ctrl,
  input  logic                                    load,
  input  logic signed [rtqi_pkg::SAMPLE_W-1:0]    sample,
  output logic signed [rtqi_pkg::HIST_W-1:0]      y
);

  localparam int HW    = rtqi_pkg::HIST_W;
  localparam int PW    = rtqi_pkg::PROD_W;
  localparam int VW    = rtqi_pkg::VSUM_W;
  localparam int CW    = rtqi_pkg::COEF_W;
  localparam int DEPTH = 2 * NUM_SECTIONS;

  // hist[0] is w0 and hist[1] is w1 of the section in work; rotate by a pair per section
  logic signed [HW-1:0] hist [DEPTH];
  logic signed [HW-1:0] x;
  logic signed [HW-1:0] wn;
  logic signed [VW-1:0] vsum;
  logic signed [PW-1:0] acc;
  logic signed [PW-1:0] prod;
  logic signed [CW:0]   mul_a;
  logic signed [VW-1:0] mul_b;
  logic signed [PW-1:0] mul_out;
  logic signed [VW-1:0] vsum_next;

  always_comb begin
    unique case (ctrl.op)
      rtqi_pkg::OP_LOADX: begin
        mul_a = $signed({1'b0, rtqi_pkg::coef_fb1(ctrl.csel)});
        mul_b = VW'(hist[0]);
      end
      rtqi_pkg::OP_SUB1: begin
        mul_a = $signed({1'b0, rtqi_pkg::coef_fb2(ctrl.csel)});
        mul_b = VW'(hist[1]);
      end
      default: begin
        mul_a = $signed({1'b0, rtqi_pkg::coef_gain(ctrl.csel)});
        mul_b = vsum;
      end
    endcase
  end

  assign mul_out   = PW'(mul_a) * PW'(mul_b);
  assign vsum_next = VW'(wn) + (VW'(hist[0]) <<< 1) + VW'(hist[1]);
  assign y         = x;

  always_ff @(posedge clk) begin
    if (load) begin
      x <= HW'(sample) <<< 8;
    end
    unique case (ctrl.op)
      rtqi_pkg::OP_LOADX: begin
        acc  <= PW'(x) <<< rtqi_pkg::FRAC_Q15;
        prod <= mul_out;
      end
      rtqi_pkg::OP_SUB1: begin
        acc  <= acc - prod;
        prod <= mul_out;
      end
      rtqi_pkg::OP_SUB2: acc  <= acc - prod;
      rtqi_pkg::OP_WN:   wn   <= rtqi_pkg::sat32(acc[PW-1:rtqi_pkg::FRAC_Q15]);
      rtqi_pkg::OP_VSUM: vsum <= vsum_next;
      rtqi_pkg::OP_MULG: prod <= mul_out;
      rtqi_pkg::OP_YOUT: x    <= rtqi_pkg::sat32(prod[PW-1:rtqi_pkg::FRAC_Q15]);
      rtqi_pkg::OP_EMIT: x    <= '0;
      default: ;
    endcase
  end

  // History is cleared by reset; rotate it once per finished section
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < DEPTH; i++) begin
        hist[i] <= '0;
      end
    end else if (ctrl.op == rtqi_pkg::OP_YOUT) begin
      for (int i = 0; i < DEPTH - 2; i++) begin
        hist[i] <= hist[i + 2];
      end
      hist[DEPTH - 2] <= wn;
      hist[DEPTH - 1] <= hist[0];
    end
  end

endmodule

### rtl/resample_three_quarter_iir_core.sv
// Top level of the 3/4 resampler: input handshake, decimation phase and output register.
//
//  channel  | dir | tdata (low bit up)      | tuser       | tlast
//  ---------+-----+-------------------------+-------------+------
//  s_*      | in  | [15:0] sample, signed   | [0] first   | -
//  m_*      | out | [15:0] out_sample       | -           | -
//
// Schedule: set by the microcode, seven steps per biquad section through the one shared
//   multiplier, plus a hold and an emit step for each of the UP_FACTOR values of an item.
// An item yields zero or one result; s_tready is high only while the sequencer waits.
// Reset: synchronous; clears the six history words, the phase, the step counter and m_tvalid.
// Stalls: a held m_tready stops the sequencer only when a new result must be written into a
//   full output register; otherwise work goes on under a waiting result.
`timescale 1ns / 1ps
`include "resample_three_quarter_iir_core_macros.svh"
module resample_three_quarter_iir_core #(
  parameter int NUM_SECTIONS = rtqi_pkg::NUM_SECTIONS_DEF,
  parameter int UP_FACTOR    = rtqi_pkg::UP_FACTOR_DEF,
  parameter int DOWN_FACTOR  = rtqi_pkg::DOWN_FACTOR_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [15:0] sample
  input  logic        s_tuser,   // [0] first
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata    // [15:0] out_sample
);

  localparam int PH_W = (DOWN_FACTOR > 1) ? $clog2(DOWN_FACTOR) : 1;

  rtqi_pkg::ctrl_t                      ctrl;
  rtqi_pkg::seq_stat_t                  stat;
  logic signed [rtqi_pkg::HIST_W-1:0]   y;
  logic [PH_W-1:0]                      phase;
  logic                                 kept;
  logic                                 keep_now;
  logic                                 item_accept;
  logic                                 emit;
  logic [15:0]                          out_sample;

  // Divide by 256 toward zero, then clamp to 16 bits
  function automatic logic [15:0] to_out(input logic signed [31:0] v);
    logic signed [32:0] t;
    logic signed [24:0] q;
    logic [15:0]        r;
    t = 33'(v) + $signed({25'b0, {8{v[31]}}});
    q = t[32:8];
    if (q[24:15] == '0 || q[24:15] == '1) begin
      r = q[15:0];
    end else if (q[24]) begin
      r = 16'h8000;
    end else begin
      r = 16'h7fff;
    end
    return r;
  endfunction

  assign s_tready    = (ctrl.op == rtqi_pkg::OP_WAIT);
  assign item_accept = s_tvalid && s_tready;
  // Report only the first kept value of an item
  assign keep_now    = (phase == '0) && !kept;
  assign emit        = (ctrl.op == rtqi_pkg::OP_EMIT);

  // Hold the sequencer only if a result must go into a full, stalled register
  assign stat.item_accept = item_accept;
  assign stat.out_stall   = keep_now && m_tvalid && !m_tready;

  rtqi_seq #(
    .NUM_SECTIONS (NUM_SECTIONS),
    .UP_FACTOR    (UP_FACTOR)
  ) u_seq (
    .clk  (clk),
    .rst  (rst),
    .stat (stat),
    .ctrl (ctrl)
  );

  rtqi_dp #(
    .NUM_SECTIONS (NUM_SECTIONS)
  ) u_dp (
    .clk    (clk),
    .rst    (rst),
    .ctrl   (ctrl),
    .load   (item_accept),
    .sample ($signed(s_tdata)),
    .y      (y)
  );

  // Decimation phase: clear on a first item, advance once per filtered value
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= '0;
      kept  <= 1'b0;
    end else begin
      if (item_accept) begin
        kept <= 1'b0;
        if (s_tuser) begin
          phase <= '0;
        end
      end
      if (emit) begin
        if (keep_now) begin
          kept <= 1'b1;
        end
        phase <= (phase == PH_W'(DOWN_FACTOR - 1)) ? '0 : phase + PH_W'(1);
      end
    end
  end

  // Output register: load a kept value, drop valid once the item is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (emit && keep_now) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit && keep_now) begin
      out_sample <= to_out(y);
    end
  end

  assign m_tdata = out_sample;

  `RTQI_ASSERT(a_no_overwrite, (emit && keep_now) |-> (!m_tvalid || m_tready), "result overwritten while stalled")
  `RTQI_ASSERT(a_first_clears_phase, (item_accept && s_tuser) |=> (phase == '0), "first item left phase set")
  `RTQI_ASSERT(a_busy_after_accept, item_accept |=> !s_tready, "sequencer did not start on accepted item")
  `RTQI_ASSERT_RST(a_reset_idle, rst |=> (!m_tvalid && s_tready), "reset did not idle the block")

endmodule
